// ===== src/cccm_pkg.sv =====
// Shared constants, types and a helper function of the capped cluster cost merge block.
`timescale 1ns / 1ps
`default_nettype none
package cccm_pkg;

    // Sizes of the cap store and of the fixed-point quotient.
    localparam int CAP_LEVELS    = 16;
    localparam int FRACTION_BITS = 16;

    // Field widths of the item interfaces and registers.
    localparam int ID_W     = 4;
    localparam int COST_W   = 32;
    localparam int RATE_W   = 5;
    localparam int SUM_W    = 63;

    // Derived widths.
    localparam int CAP_W      = (CAP_LEVELS > 1) ? $clog2(CAP_LEVELS) : 1;
    localparam int HX_W       = $clog2(CAP_LEVELS + 1);
    localparam int DIV_W      = COST_W + FRACTION_BITS;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = (DIV_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W      = NUM_DIGITS * DIGIT_W;
    localparam int ASM_W      = PAD_W - DIGIT_W;
    localparam int DCNT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SUM_W;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_RAW = ID_W + COST_W;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_RAW = ID_W + SUM_W + ID_W + ID_W;
    localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

    // Saturation value of the sums and reset values of the registers.
    localparam logic [SUM_W-1:0]  SUM_MAX     = '1;
    localparam logic [SUM_W-1:0]  LIMIT_RESET = '1;
    localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(2);

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_ZERO = 3'd0,
        CFG_RATE_ONE  = 3'd1,
        CFG_RATE_TWO  = 3'd2,
        CFG_RATE_TAIL = 3'd3,
        CFG_LIMIT     = 3'd4
    } cfg_reg_t;

    // Configuration register file.
    typedef struct packed {
        logic [RATE_W-1:0] rate_zero;
        logic [RATE_W-1:0] rate_one;
        logic [RATE_W-1:0] rate_two;
        logic [RATE_W-1:0] rate_tail;
        logic [SUM_W-1:0]  limit;
    } cfg_t;

    // One digit of a dividend moving down the cell chain, with its item context.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              final_dig;
        logic              last_cell;
        logic [CAP_W-1:0]  id;
        logic [CAP_W-1:0]  top;
        logic [HX_W-1:0]   hx;
        logic [DIGIT_W-1:0] digit;
    } tok_t;

    // Control from the report unit to the chain and the feed logic.
    typedef struct packed {
        logic shift;
        logic done;
    } rpt_ctl_t;

    // Report unit states.
    typedef enum logic {
        RPT_IDLE,
        RPT_SEND
    } rpt_state_t;

    // Divisor used between cluster level and level plus one; zero divides by one.
    function automatic logic [RATE_W-1:0] level_rate(input logic [CAP_W-1:0] level,
                                                     input cfg_t cfg);
        logic [RATE_W-1:0] r;
        if (level == CAP_W'(0)) begin
            r = cfg.rate_zero;
        end else if (level == CAP_W'(1)) begin
            r = cfg.rate_one;
        end else if (level == CAP_W'(2)) begin
            r = cfg.rate_two;
        end else begin
            r = cfg.rate_tail;
        end
        return (r == '0) ? RATE_W'(1) : r;
    endfunction

endpackage
`default_nettype wire

// ===== src/capped_cluster_cost_merge_core.sv =====
// Top level: config registers, digit feed, chain of cap cells and report unit.
// Each item enters as NUM_DIGITS digits; a dividing cell yields 8 quotient bits a cycle.
// An item's sums are final once its final digit has been taken by the last cell.
// A last cell then yields highest-id + 1 results, once its final digit leaves the chain.
// Input is held off from acceptance of a last cell until its final result is loaded.
// Reset (synchronous, aresetn low): sums and highest id cleared, rates 2, limit all ones.
`timescale 1ns / 1ps
`default_nettype none
module capped_cluster_cost_merge_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata fields from bit 0: cluster_id, cell_cost, zero fill.
    input  wire logic [cccm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tlast,
    output logic                                   s_tready,
    // m_tdata fields from bit 0: cap_index, capped_cost, merged_max_cluster,
    // highest_cluster_seen, zero fill.
    output logic [cccm_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tvalid,
    output logic                                   m_tlast,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_wr_en,
    input  wire logic [cccm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cccm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam logic [cccm_pkg::DCNT_W-1:0] LAST_DIG = cccm_pkg::DCNT_W'(cccm_pkg::NUM_DIGITS - 1);

    cccm_pkg::cfg_t                    cfg_reg, cfg_next;
    logic                              busy_reg, busy_next;
    logic                              hold_reg, hold_next;
    logic [cccm_pkg::DCNT_W-1:0]       dcnt_reg, dcnt_next;
    logic [cccm_pkg::PAD_W-1:0]        shreg_reg, shreg_next;
    logic [cccm_pkg::CAP_W-1:0]        id_reg, id_next;
    logic                              last_reg, last_next;
    logic [cccm_pkg::CAP_W-1:0]        max_seen_reg, max_seen_next;
    logic [cccm_pkg::ID_W-1:0]         in_id;
    logic [cccm_pkg::COST_W-1:0]       in_cost;
    logic [cccm_pkg::CAP_W-1:0]        id_sat;
    logic                              accept;
    cccm_pkg::rpt_ctl_t                ctl;
    cccm_pkg::tok_t                    tok_chain [cccm_pkg::CAP_LEVELS + 1];
    logic [cccm_pkg::SUM_W-1:0]        sum_chain [cccm_pkg::CAP_LEVELS];

    // Configuration register writes; unknown indexes are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cccm_pkg::cfg_reg_t'(cfg_index))
                cccm_pkg::CFG_RATE_ZERO: cfg_next.rate_zero = cfg_wdata[cccm_pkg::RATE_W-1:0];
                cccm_pkg::CFG_RATE_ONE:  cfg_next.rate_one  = cfg_wdata[cccm_pkg::RATE_W-1:0];
                cccm_pkg::CFG_RATE_TWO:  cfg_next.rate_two  = cfg_wdata[cccm_pkg::RATE_W-1:0];
                cccm_pkg::CFG_RATE_TAIL: cfg_next.rate_tail = cfg_wdata[cccm_pkg::RATE_W-1:0];
                cccm_pkg::CFG_LIMIT:     cfg_next.limit     = cfg_wdata[cccm_pkg::SUM_W-1:0];
                default: ;
            endcase
        end
    end

    // Input fields, with ids above the store held at the top cap.
    assign in_id   = s_tdata[cccm_pkg::ID_W-1:0];
    assign in_cost = s_tdata[cccm_pkg::ID_W +: cccm_pkg::COST_W];

    always_comb begin
        if (int'(in_id) > cccm_pkg::CAP_LEVELS - 1) begin
            id_sat = cccm_pkg::CAP_W'(cccm_pkg::CAP_LEVELS - 1);
        end else begin
            id_sat = cccm_pkg::CAP_W'(in_id);
        end
    end

    // A new item enters as the previous one sends its final digit.
    assign s_tready = !hold_reg && (!busy_reg || (dcnt_reg == LAST_DIG));
    assign accept   = s_tvalid && s_tready;

    // Feed: shifts the scaled cost into the chain one digit per cycle, MSB first.
    always_comb begin
        busy_next     = busy_reg;
        hold_next     = hold_reg;
        dcnt_next     = dcnt_reg;
        shreg_next    = shreg_reg;
        id_next       = id_reg;
        last_next     = last_reg;
        max_seen_next = max_seen_reg;
        if (busy_reg) begin
            shreg_next = shreg_reg << cccm_pkg::DIGIT_W;
            dcnt_next  = dcnt_reg + cccm_pkg::DCNT_W'(1);
            if (dcnt_reg == LAST_DIG) begin
                busy_next = 1'b0;
            end
        end
        if (accept) begin
            busy_next  = 1'b1;
            dcnt_next  = '0;
            shreg_next = cccm_pkg::PAD_W'(in_cost) << cccm_pkg::FRACTION_BITS;
            id_next    = id_sat;
            last_next  = s_tlast;
            hold_next  = s_tlast;
            if (id_sat > max_seen_reg) begin
                max_seen_next = id_sat;
            end
        end
        if (ctl.done) begin
            hold_next     = 1'b0;
            max_seen_next = '0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_zero <= cccm_pkg::RATE_RESET;
            cfg_reg.rate_one  <= cccm_pkg::RATE_RESET;
            cfg_reg.rate_two  <= cccm_pkg::RATE_RESET;
            cfg_reg.rate_tail <= cccm_pkg::RATE_RESET;
            cfg_reg.limit     <= cccm_pkg::LIMIT_RESET;
            busy_reg          <= 1'b0;
            hold_reg          <= 1'b0;
            dcnt_reg          <= '0;
            max_seen_reg      <= '0;
        end else begin
            cfg_reg      <= cfg_next;
            busy_reg     <= busy_next;
            hold_reg     <= hold_next;
            dcnt_reg     <= dcnt_next;
            max_seen_reg <= max_seen_next;
        end
    end

    // Feed payload registers.
    always_ff @(posedge aclk) begin
        shreg_reg <= shreg_next;
        id_reg    <= id_next;
        last_reg  <= last_next;
    end

    // Digit entering the first cell.
    always_comb begin
        tok_chain[0]           = '0;
        tok_chain[0].valid     = busy_reg;
        tok_chain[0].first     = (dcnt_reg == '0);
        tok_chain[0].final_dig = (dcnt_reg == LAST_DIG);
        tok_chain[0].last_cell = last_reg;
        tok_chain[0].id        = id_reg;
        tok_chain[0].top       = max_seen_reg;
        tok_chain[0].digit     = shreg_reg[cccm_pkg::PAD_W-1 -: cccm_pkg::DIGIT_W];
    end

    // Chain of cap cells; during a report the sums move toward cell zero.
    for (genvar k = 0; k < cccm_pkg::CAP_LEVELS; k++) begin : g_cell
        logic [cccm_pkg::SUM_W-1:0]  sum_from_next;
        logic [cccm_pkg::RATE_W-1:0] cell_rate;

        if (k == cccm_pkg::CAP_LEVELS - 1) begin : g_tail
            assign sum_from_next = '0;
        end else begin : g_body
            assign sum_from_next = sum_chain[k + 1];
        end

        assign cell_rate = cccm_pkg::level_rate(cccm_pkg::CAP_W'(k), cfg_reg);

        cccm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (cccm_pkg::CAP_W'(k)),
            .rate     (cell_rate),
            .limit    (cfg_reg.limit),
            .tok_in   (tok_chain[k]),
            .ctl      (ctl),
            .sum_in   (sum_from_next),
            .tok_out  (tok_chain[k + 1]),
            .sum_out  (sum_chain[k])
        );
    end

    // Result sequencing and output register.
    cccm_report u_report (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .chain_tok (tok_chain[cccm_pkg::CAP_LEVELS]),
        .head_sum  (sum_chain[0]),
        .ctl       (ctl),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .m_tready  (m_tready)
    );

    // The end of a set reaches the report unit only while intake is held off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_chain[cccm_pkg::CAP_LEVELS].valid && tok_chain[cccm_pkg::CAP_LEVELS].final_dig
         && tok_chain[cccm_pkg::CAP_LEVELS].last_cell) |-> hold_reg)
        else $error("set end left the chain without intake held");

    // After an item's final digit the feed either idles or starts a new item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_chain[0].valid && tok_chain[0].final_dig) |=>
        (!tok_chain[0].valid || tok_chain[0].first))
        else $error("feed digit count out of step");

endmodule
`default_nettype wire

// ===== src/cccm_cell.sv =====
// One cap cell: digit-serial divider stage and saturating cost accumulator.
`timescale 1ns / 1ps
`default_nettype none
module cccm_cell (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [cccm_pkg::CAP_W-1:0]   cell_idx,
    input  wire logic [cccm_pkg::RATE_W-1:0]  rate,
    input  wire logic [cccm_pkg::SUM_W-1:0]   limit,
    input  wire cccm_pkg::tok_t               tok_in,
    input  wire cccm_pkg::rpt_ctl_t           ctl,
    input  wire logic [cccm_pkg::SUM_W-1:0]   sum_in,
    output cccm_pkg::tok_t                    tok_out,
    output logic [cccm_pkg::SUM_W-1:0]        sum_out
);

    cccm_pkg::tok_t                      tok_reg, tok_next;
    logic [cccm_pkg::RATE_W-1:0]         rem_reg, rem_next;
    logic [cccm_pkg::ASM_W-1:0]          asm_reg, asm_next;
    logic [cccm_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [cccm_pkg::RATE_W-1:0]         rem;
    logic [cccm_pkg::RATE_W:0]           trial;
    logic [cccm_pkg::DIGIT_W-1:0]        q_digit;
    logic [cccm_pkg::PAD_W-1:0]          full_val;
    logic [cccm_pkg::SUM_W:0]            sum_wide;
    logic [cccm_pkg::SUM_W-1:0]          sum_sat;
    logic                                do_div;
    logic                                exceed;

    // Long division of one dividend digit by this cell's rate, one bit per step.
    always_comb begin
        rem     = tok_in.first ? '0 : rem_reg;
        q_digit = '0;
        trial   = '0;
        for (int b = cccm_pkg::DIGIT_W - 1; b >= 0; b--) begin
            trial = {rem, tok_in.digit[b]};
            if (trial >= {1'b0, rate}) begin
                q_digit[b] = 1'b1;
                rem        = cccm_pkg::RATE_W'(trial - {1'b0, rate});
            end else begin
                rem        = trial[cccm_pkg::RATE_W-1:0];
            end
        end
    end

    // Cells at or above the item's cluster id pass the dividend through unchanged.
    assign do_div = (cell_idx < tok_in.id);

    // The whole quotient of this level is ready when its final digit arrives.
    assign full_val = {asm_reg, tok_in.digit};
    assign sum_wide = {1'b0, sum_reg} + (cccm_pkg::SUM_W + 1)'(full_val);
    assign sum_sat  = sum_wide[cccm_pkg::SUM_W] ? cccm_pkg::SUM_MAX
                                                : sum_wide[cccm_pkg::SUM_W-1:0];
    assign exceed   = (sum_sat > limit);

    // Next token, remainder, assembly and sum.
    always_comb begin
        tok_next       = tok_in;
        tok_next.digit = do_div ? q_digit : tok_in.digit;
        rem_next       = rem_reg;
        asm_next       = asm_reg;
        sum_next       = sum_reg;
        if (tok_in.valid) begin
            rem_next = rem;
            asm_next = full_val[cccm_pkg::ASM_W-1:0];
            if (tok_in.final_dig) begin
                sum_next = sum_sat;
                if (tok_in.last_cell && exceed && (cell_idx <= tok_in.top)) begin
                    tok_next.hx = cccm_pkg::HX_W'(cell_idx) + cccm_pkg::HX_W'(1);
                end
            end
        end
        if (ctl.done) begin
            sum_next = '0;
        end else if (ctl.shift) begin
            sum_next = sum_in;
        end
    end

    // Control state and sums.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
            sum_reg <= '0;
        end else begin
            tok_reg <= tok_next;
            sum_reg <= sum_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        asm_reg <= asm_next;
    end

    assign tok_out = tok_reg;
    assign sum_out = sum_reg;

    // Within one item the carried remainder always stays below the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_in.valid && !tok_in.first && do_div) |-> (rem_reg < rate))
        else $error("cell remainder not below its rate");

endmodule
`default_nettype wire

// ===== src/cccm_report.sv =====
// Report unit: shifts the cap sums out of the chain as result items.
`timescale 1ns / 1ps
`default_nettype none
module cccm_report (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cccm_pkg::tok_t                chain_tok,
    input  wire logic [cccm_pkg::SUM_W-1:0]    head_sum,
    output cccm_pkg::rpt_ctl_t                 ctl,
    // m_tdata fields from bit 0: cap_index, capped_cost, merged_max_cluster,
    // highest_cluster_seen, zero fill.
    output logic [cccm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    output logic                               m_tlast,
    input  wire logic                          m_tready
);

    cccm_pkg::rpt_state_t            state_reg, state_next;
    logic [cccm_pkg::CAP_W-1:0]      cnt_reg, cnt_next;
    logic [cccm_pkg::CAP_W-1:0]      top_reg, top_next;
    logic [cccm_pkg::CAP_W-1:0]      merged_reg, merged_next;
    logic                            m_valid_reg, m_valid_next;
    logic [cccm_pkg::ID_W-1:0]       out_idx_reg, out_idx_next;
    logic [cccm_pkg::SUM_W-1:0]      out_cost_reg, out_cost_next;
    logic [cccm_pkg::ID_W-1:0]       out_merged_reg, out_merged_next;
    logic [cccm_pkg::ID_W-1:0]       out_top_reg, out_top_next;
    logic                            out_last_reg, out_last_next;
    logic                            load;
    logic                            set_end;
    logic [cccm_pkg::CAP_W-1:0]      merged_cand;

    // The final digit of a set's last cell leaving the chain starts a report.
    assign set_end = chain_tok.valid && chain_tok.final_dig && chain_tok.last_cell;

    // One above the highest exceeding cap, held at the highest id; zero if none.
    always_comb begin
        if (chain_tok.hx == '0) begin
            merged_cand = '0;
        end else if (chain_tok.hx > cccm_pkg::HX_W'(chain_tok.top)) begin
            merged_cand = chain_tok.top;
        end else begin
            merged_cand = cccm_pkg::CAP_W'(chain_tok.hx);
        end
    end

    assign load = (state_reg == cccm_pkg::RPT_SEND) && (!m_valid_reg || m_tready);

    // Next state and outputs.
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        top_next        = top_reg;
        merged_next     = merged_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_idx_next    = out_idx_reg;
        out_cost_next   = out_cost_reg;
        out_merged_next = out_merged_reg;
        out_top_next    = out_top_reg;
        out_last_next   = out_last_reg;
        ctl             = '0;
        unique case (state_reg)
            cccm_pkg::RPT_IDLE: begin
                if (set_end) begin
                    top_next    = chain_tok.top;
                    merged_next = merged_cand;
                    cnt_next    = '0;
                    state_next  = cccm_pkg::RPT_SEND;
                end
            end
            cccm_pkg::RPT_SEND: begin
                if (load) begin
                    m_valid_next    = 1'b1;
                    out_idx_next    = cccm_pkg::ID_W'(cnt_reg);
                    out_cost_next   = head_sum;
                    out_merged_next = cccm_pkg::ID_W'(merged_reg);
                    out_top_next    = cccm_pkg::ID_W'(top_reg);
                    out_last_next   = (cnt_reg == top_reg);
                    ctl.shift       = 1'b1;
                    cnt_next        = cnt_reg + cccm_pkg::CAP_W'(1);
                    if (cnt_reg == top_reg) begin
                        ctl.done   = 1'b1;
                        state_next = cccm_pkg::RPT_IDLE;
                    end
                end
            end
            default: begin
                state_next = cccm_pkg::RPT_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cccm_pkg::RPT_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        top_reg        <= top_next;
        merged_reg     <= merged_next;
        out_idx_reg    <= out_idx_next;
        out_cost_reg   <= out_cost_next;
        out_merged_reg <= out_merged_next;
        out_top_reg    <= out_top_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = cccm_pkg::M_TDATA_W'({out_top_reg, out_merged_reg,
                                            out_cost_reg, out_idx_reg});

    // A shown result never names a merged id above the highest id seen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_merged_reg <= out_top_reg))
        else $error("merged id above highest id seen");

    // Loading the result of the highest cap ends the report.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && (cnt_reg == top_reg)) |=> (state_reg == cccm_pkg::RPT_IDLE))
        else $error("report did not end after its final result");

endmodule
`default_nettype wire
